FILE: rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// LED blink controller package
// Shared types, codes and sizing constants for the blink controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

  localparam int unsigned LevelBitsDefault = 8;
  localparam int unsigned DelayBitsDefault = 16;

  localparam int unsigned CmdWidth   = 2;
  localparam int unsigned LevelWidth = 8;
  localparam int unsigned CfgWidth   = 16;

  typedef enum logic [CmdWidth-1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET_LEVEL = 2'd1,
    CMD_FLASH_ON  = 2'd2,
    CMD_FLASH_OFF = 2'd3
  } lbc_cmd_e;

  typedef enum logic [0:0] {
    CFG_ON_TIME  = 1'b0,
    CFG_OFF_TIME = 1'b1
  } lbc_cfg_e;

  typedef struct packed {
    lbc_cmd_e              cmd;
    logic [LevelWidth-1:0] level;
  } lbc_req_t;

  typedef struct packed {
    logic [LevelWidth-1:0] led_level;
    logic                  flashing;
  } lbc_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/lbc_req_if.sv
// ----------------------------------------------------------------------------
// LED blink controller request channel
// Valid/ready channel carrying commands and brightness levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbc_req_if;
  logic              valid;
  logic              ready;
  lbc_pkg::lbc_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/lbc_rsp_if.sv
// ----------------------------------------------------------------------------
// LED blink controller response channel
// Valid/ready channel carrying the LED level and the blink status.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbc_rsp_if;
  logic              valid;
  logic              ready;
  lbc_pkg::lbc_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/led_blink_controller.sv
// ----------------------------------------------------------------------------
// LED blink controller
// Millisecond-tick driven LED brightness and blink sequencer.
//
// Usage:
//   req_i carries one request per handshake: a tick, a brightness write,
//   flash on or flash off. Each accepted request yields exactly one
//   response on rsp_o with the LED level and the blink flag after the
//   update, in request order.
//   The state updates at the accepting edge and the response is registered
//   in the output buffer. Throughput is one request per cycle while the
//   output buffer is not full.
//   A two-entry output buffer holds responses; req_i.ready drops only
//   when both entries are full, so a stalled receiver back-pressures the
//   request side after two pending responses.
//   The user writes on/off times through cfg_we_i/cfg_idx_i/cfg_data_i
//   only while no request is in flight; the block does not enforce it.
//   Reset clears all levels, the countdown, the blink flag, the times and
//   the output buffer; the block accepts requests right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module led_blink_controller #(
  parameter int unsigned LEVEL_BITS = lbc_pkg::LevelBitsDefault,
  parameter int unsigned DELAY_BITS = lbc_pkg::DelayBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire lbc_pkg::lbc_cfg_e             cfg_idx_i,
  input  wire logic [lbc_pkg::CfgWidth-1:0]  cfg_data_i,
  lbc_req_if.sink                            req_i,
  lbc_rsp_if.source                          rsp_o
);

  localparam logic [LEVEL_BITS-1:0] LevelFull = {LEVEL_BITS{1'b1}};
  localparam logic [DELAY_BITS-1:0] DelayOne  = DELAY_BITS'(1);

  logic [DELAY_BITS-1:0] on_time_q, off_time_q;
  logic [LEVEL_BITS-1:0] cur_q, cur_d, steady_q, steady_d, blink_q, blink_d;
  logic                  active_q, active_d;
  logic [DELAY_BITS-1:0] ticks_q, ticks_d;

  logic [31:0]           cfg_wide;
  logic [15:0]           lvl_in_wide, lvl_out_wide;
  logic [LEVEL_BITS-1:0] lvl_in;
  logic                  push, pop;
  lbc_pkg::lbc_rsp_t     rsp_new;

  logic                  o_valid_q, s_valid_q;
  lbc_pkg::lbc_rsp_t     o_data_q, s_data_q;

  assign cfg_wide    = 32'(cfg_data_i);
  assign lvl_in_wide = 16'(req_i.payload.level);
  assign lvl_in      = lvl_in_wide[LEVEL_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_time_q  <= '0;
      off_time_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lbc_pkg::CFG_ON_TIME:  on_time_q  <= cfg_wide[DELAY_BITS-1:0];
        lbc_pkg::CFG_OFF_TIME: off_time_q <= cfg_wide[DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign push        = req_i.valid && req_i.ready;
  assign pop         = o_valid_q && rsp_o.ready;
  assign req_i.ready = !s_valid_q;

  always_comb begin
    cur_d    = cur_q;
    steady_d = steady_q;
    blink_d  = blink_q;
    active_d = active_q;
    ticks_d  = ticks_q;
    unique case (req_i.payload.cmd)
      lbc_pkg::CMD_TICK: begin
        if (active_q) begin
          if (ticks_q > DelayOne) begin
            ticks_d = ticks_q - DelayOne;
          end else if (on_time_q == '0 || off_time_q == '0) begin
            active_d = 1'b0;
            cur_d    = steady_q;
            ticks_d  = '0;
          end else if (cur_q == '0) begin
            cur_d   = blink_q;
            ticks_d = on_time_q;
          end else begin
            if (cur_q != blink_q) begin
              steady_d = cur_q;
              blink_d  = cur_q;
            end
            cur_d   = '0;
            ticks_d = off_time_q;
          end
        end
      end
      lbc_pkg::CMD_SET_LEVEL: begin
        cur_d = lvl_in;
      end
      lbc_pkg::CMD_FLASH_ON: begin
        if (!active_q) begin
          steady_d = cur_q;
          blink_d  = (cur_q == '0) ? LevelFull : cur_q;
          active_d = 1'b1;
          ticks_d  = DelayOne;
        end
      end
      lbc_pkg::CMD_FLASH_OFF: begin
        if (active_q) begin
          active_d = 1'b0;
          ticks_d  = '0;
          cur_d    = steady_q;
        end
      end
      default: ;
    endcase
  end

  assign lvl_out_wide      = 16'(cur_d);
  assign rsp_new.led_level = lvl_out_wide[lbc_pkg::LevelWidth-1:0];
  assign rsp_new.flashing  = active_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      steady_q <= '0;
      blink_q  <= '0;
      active_q <= 1'b0;
      ticks_q  <= '0;
    end else if (push) begin
      cur_q    <= cur_d;
      steady_q <= steady_d;
      blink_q  <= blink_d;
      active_q <= active_d;
      ticks_q  <= ticks_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (pop) begin
      if (s_valid_q) begin
        s_valid_q <= 1'b0;
      end else begin
        o_valid_q <= push;
      end
    end else if (push) begin
      if (o_valid_q) begin
        s_valid_q <= 1'b1;
      end else begin
        o_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (s_valid_q) begin
        o_data_q <= s_data_q;
      end else if (push) begin
        o_data_q <= rsp_new;
      end
    end else if (push) begin
      if (o_valid_q) begin
        s_data_q <= rsp_new;
      end else begin
        o_data_q <= rsp_new;
      end
    end
  end

  assign rsp_o.valid   = o_valid_q;
  assign rsp_o.payload = o_data_q;

endmodule

`default_nettype wire
